// ----- hw/rtl/sgns_pkg.sv -----
// shared constants, types and sigmoid table builder for the gradient step block
package sgns_pkg;

  localparam int ROW_W = 10;
  localparam int EL_W = 9;
  localparam int ADDR_W = ROW_W + EL_W;
  localparam int MAX_DIM = 512;
  localparam int DIM_W = 10;
  localparam int TABLE_ENTRIES = 1000;
  localparam int SIG_SCALE = TABLE_ENTRIES / 6 / 2;
  localparam int ROM_AW = 10;
  localparam logic [DIM_W-1:0] DIM_RESET = 10'd300;
  localparam logic signed [39:0] SIX_Q24 = 40'sd100663296;

  localparam logic [2:0] OP_WR_IN = 3'd0;
  localparam logic [2:0] OP_WR_OUT = 3'd1;
  localparam logic [2:0] OP_TRAIN = 3'd2;
  localparam logic [2:0] OP_RD_IN = 3'd3;
  localparam logic [2:0] OP_RD_OUT = 3'd4;
  localparam logic [2:0] OP_RD_ERR = 3'd5;

  typedef logic [16:0] rom_t [TABLE_ENTRIES];

  // shift-subtract quotient, evaluated only while the table is built
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] rom_entry(int i);
    longint m;
    longint unsigned a, u, term, e, num, den, one31;
    longint sum;
    m = 2 * longint'(i) - longint'(TABLE_ENTRIES);
    a = (m < 0) ? longint'(-m) : longint'(m);
    one31 = 64'd1 << 31;
    u = udiv((6 * a) << 25, longint'(TABLE_ENTRIES));
    term = one31;
    sum = longint'(one31);
    for (int k = 1; k <= 12; k++) begin
      term = udiv((term * u) >> 31, longint'(k));
      if ((k & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    e = (sum < 0) ? 64'd0 : longint'(sum);
    for (int k = 0; k < 6; k++) e = (e * e) >> 31;
    num = (m >= 0) ? one31 : e;
    den = one31 + e;
    return 17'(udiv((num << 16) + (den >> 1), den));
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TABLE_ENTRIES; i++) r[i] = rom_entry(i);
    return r;
  endfunction

endpackage

// ----- hw/rtl/sgns_ram.sv -----
// generic single-write, single-read ram with registered read data
module sgns_ram #(
  parameter int W = 16,
  parameter int AW = 19
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sgns_gradient_step.sv -----
// skip-gram negative-sampling gradient step over fixed-point embedding tables
//
//  channel | signals                       | beat contents
//  s       | s_tvalid s_tready s_tdata s_tuser | one operation item
//  m       | m_tvalid m_tready m_tdata     | one result item
//  cfg     | cfg_valid cfg_ready cfg_data  | dim_in_use write
//
// train runs one element per cycle through the
// embedding ram read port in a dot pass and again in an update pass
// reads pass through a wait state for the ram data, writes and rejected items do not
// after reset a clear pass zeroes the error ram before any item is taken
// a finished result waits in the output register while the next item is taken
// cfg beats are taken only while idle with no item offered
module sgns_gradient_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // input_row[9:0] target_row[19:10] element[28:20] write_value[44:29]
  // label[45] learning_rate[61:46]
  input  logic [63:0] s_tdata,
  // operation[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_value[31:0] prediction[48:32] status[49]
  output logic [55:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);

  localparam sgns_pkg::rom_t SIG_ROM = sgns_pkg::build_rom();

  typedef enum logic [2:0] {
    CLEAR, IDLE, DOT, SIG, SIG2, GAIN, UPD, RDWAIT
  } state_t;

  state_t state;
  logic finish;

  logic [sgns_pkg::DIM_W-1:0] dim_in_use, dim;
  logic [sgns_pkg::DIM_W-1:0] cnt;
  logic [2:0] op;
  logic [sgns_pkg::ROW_W-1:0] irow, trow;
  logic [sgns_pkg::EL_W-1:0] el, c1, c2;
  logic label;
  logic [15:0] rate;

  logic [sgns_pkg::ROW_W-1:0] s_irow, s_trow;
  logic [sgns_pkg::EL_W-1:0] s_el;
  logic [15:0] s_wv, s_rate;
  logic s_label;

  logic signed [31:0] prod;
  logic signed [40:0] acc;
  logic [16:0] pred, rom_q;
  logic signed [34:0] g;
  logic signed [50:0] mg_out, mg_in;
  logic [31:0] err1;
  logic [15:0] outv1;
  logic p1_v, p2_v, issue_v;

  logic [31:0] res_rd;
  logic [16:0] res_pred;
  logic res_status;

  logic in_we, out_we, err_we;
  logic [sgns_pkg::ADDR_W-1:0] in_waddr, out_waddr, in_raddr, out_raddr;
  logic [15:0] in_wdata, out_wdata, in_q, out_q;
  logic [sgns_pkg::EL_W-1:0] err_waddr, err_raddr;
  logic [31:0] err_wdata, err_q;

  logic accept;
  logic signed [40:0] shifted;
  logic [34:0] scaled;
  logic [sgns_pkg::ROM_AW-1:0] rom_idx;
  logic signed [51:0] sum_o, sum_i;
  logic signed [19:0] rnd_o, rnd_i;
  logic signed [32:0] err_new;
  logic signed [20:0] out_new;
  logic [31:0] err_sat;
  logic [15:0] out_sat;
  logic signed [17:0] diff;

  assign s_irow = s_tdata[9:0];
  assign s_trow = s_tdata[19:10];
  assign s_el = s_tdata[28:20];
  assign s_wv = s_tdata[44:29];
  assign s_label = s_tdata[45];
  assign s_rate = s_tdata[61:46];

  assign cfg_ready = (state == IDLE) && !finish && !s_tvalid;
  assign s_tready = (state == IDLE) && !finish;
  assign accept = s_tvalid && s_tready;
  assign dim = (dim_in_use > 10'(sgns_pkg::MAX_DIM)) ? 10'(sgns_pkg::MAX_DIM) : dim_in_use;
  assign issue_v = ((state == DOT) || (state == UPD)) && (cnt < dim);

  // sigmoid table index
  assign shifted = acc + sgns_pkg::SIX_Q24;
  assign scaled = 35'(shifted[27:0]) * 35'(sgns_pkg::SIG_SCALE);
  assign rom_idx = (scaled[34:24] >= 11'(sgns_pkg::TABLE_ENTRIES))
                   ? 10'(sgns_pkg::TABLE_ENTRIES - 1) : scaled[33:24];

  assign diff = $signed({1'b0, label, 16'b0}) - $signed({1'b0, pred});

  // update rounding and saturation
  assign sum_o = {mg_out[50], mg_out} + 52'sh80000000;
  assign sum_i = {mg_in[50], mg_in} + 52'sh80000000;
  assign rnd_o = sum_o[51:32];
  assign rnd_i = sum_i[51:32];
  assign err_new = $signed({err1[31], err1}) + 33'(rnd_o);
  assign out_new = $signed({{5{outv1[15]}}, outv1}) + 21'(rnd_i);
  always_comb begin
    if (err_new[32] != err_new[31]) err_sat = err_new[32] ? 32'h80000000 : 32'h7fffffff;
    else err_sat = err_new[31:0];
    if (out_new > 21'sd32767) out_sat = 16'h7fff;
    else if (out_new < -21'sd32768) out_sat = 16'h8000;
    else out_sat = out_new[15:0];
  end

  // ram ports
  always_comb begin
    in_we = accept && (s_tuser == sgns_pkg::OP_WR_IN) && (10'(s_el) < dim);
    in_waddr = {s_irow, s_el};
    in_wdata = s_wv;
    out_we = 1'b0;
    out_waddr = {s_trow, s_el};
    out_wdata = s_wv;
    err_we = 1'b0;
    err_waddr = cnt[sgns_pkg::EL_W-1:0];
    err_wdata = '0;
    if (accept && (s_tuser == sgns_pkg::OP_WR_OUT) && (10'(s_el) < dim)) out_we = 1'b1;
    if (state == CLEAR) err_we = 1'b1;
    if ((state == RDWAIT) && (op == sgns_pkg::OP_RD_ERR)) begin
      err_we = 1'b1;
      err_waddr = el;
    end
    if ((state == UPD) && p2_v) begin
      out_we = 1'b1;
      out_waddr = {trow, c2};
      out_wdata = out_sat;
      err_we = 1'b1;
      err_waddr = c2;
      err_wdata = err_sat;
    end
    if (state == IDLE) begin
      in_raddr = {s_irow, s_el};
      out_raddr = {s_trow, s_el};
      err_raddr = s_el;
    end else begin
      in_raddr = {irow, cnt[sgns_pkg::EL_W-1:0]};
      out_raddr = {trow, cnt[sgns_pkg::EL_W-1:0]};
      err_raddr = cnt[sgns_pkg::EL_W-1:0];
    end
  end

  sgns_ram #(.W(16), .AW(sgns_pkg::ADDR_W)) u_in_ram (
    .clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
    .raddr(in_raddr), .rdata(in_q)
  );

  sgns_ram #(.W(16), .AW(sgns_pkg::ADDR_W)) u_out_ram (
    .clk(clk), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
    .raddr(out_raddr), .rdata(out_q)
  );

  sgns_ram #(.W(32), .AW(sgns_pkg::EL_W)) u_err_ram (
    .clk(clk), .we(err_we), .waddr(err_waddr), .wdata(err_wdata),
    .raddr(err_raddr), .rdata(err_q)
  );

  always_ff @(posedge clk) begin
    rom_q <= SIG_ROM[rom_idx];
    prod <= $signed(in_q) * $signed(out_q);
    mg_out <= g * $signed(out_q);
    mg_in <= g * $signed(in_q);
    err1 <= err_q;
    outv1 <= out_q;
    c1 <= cnt[sgns_pkg::EL_W-1:0];
    c2 <= c1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      cnt <= '0;
      finish <= 1'b0;
      m_tvalid <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      dim_in_use <= sgns_pkg::DIM_RESET;
    end else begin
      if (cfg_valid && cfg_ready) dim_in_use <= cfg_data;
      p1_v <= issue_v;
      p2_v <= p1_v;
      if (issue_v) cnt <= cnt + 10'd1;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (finish && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata <= {6'b0, res_status, res_pred, res_rd};
        finish <= 1'b0;
      end
      case (state)
        CLEAR: begin
          cnt <= cnt + 10'd1;
          if (cnt == 10'(sgns_pkg::MAX_DIM - 1)) state <= IDLE;
        end
        IDLE: begin
          if (accept) begin
            op <= s_tuser;
            irow <= s_irow;
            trow <= s_trow;
            el <= s_el;
            label <= s_label;
            rate <= s_rate;
            acc <= '0;
            cnt <= '0;
            res_rd <= '0;
            res_pred <= '0;
            res_status <= 1'b0;
            if (s_tuser == sgns_pkg::OP_TRAIN) begin
              state <= DOT;
            end else if (s_tuser > sgns_pkg::OP_RD_ERR) begin
              finish <= 1'b1;
            end else if (10'(s_el) >= dim) begin
              res_status <= 1'b1;
              finish <= 1'b1;
            end else if (s_tuser >= sgns_pkg::OP_RD_IN) begin
              state <= RDWAIT;
            end else begin
              finish <= 1'b1;
            end
          end
        end
        DOT: begin
          if (p2_v) acc <= acc + {{9{prod[31]}}, prod};
          if (!issue_v && !p1_v && !p2_v) state <= SIG;
        end
        SIG: state <= SIG2;
        SIG2: begin
          if (acc > sgns_pkg::SIX_Q24) pred <= 17'd65536;
          else if (acc < -sgns_pkg::SIX_Q24) pred <= 17'd0;
          else pred <= rom_q;
          state <= GAIN;
        end
        GAIN: begin
          g <= diff * $signed({1'b0, rate});
          cnt <= '0;
          state <= UPD;
        end
        UPD: begin
          if (!issue_v && !p1_v && !p2_v) begin
            res_pred <= pred;
            finish <= 1'b1;
            state <= IDLE;
          end
        end
        RDWAIT: begin
          case (op)
            sgns_pkg::OP_RD_IN: res_rd <= {{16{in_q[15]}}, in_q};
            sgns_pkg::OP_RD_OUT: res_rd <= {{16{out_q[15]}}, out_q};
            default: res_rd <= err_q;
          endcase
          finish <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sgns_gradient_step_tb.sv -----
// self-checking testbench for the skip-gram gradient step block
module sgns_gradient_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int FILL_EL = 64;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  irow;
    logic [9:0]  trow;
    logic [8:0]  el;
    logic [15:0] wval;
    logic        lab;
    logic [15:0] rate;
  } step_item_t;

  typedef struct packed {
    logic [31:0] rd;
    logic [16:0] pred;
    logic        st;
  } step_result_t;

  typedef struct packed {
    step_item_t   it;
    logic         fixed;
    step_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;

  sgns_gradient_step dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] in_vec [0:(1<<sgns_pkg::ADDR_W)-1];
  logic signed [15:0] out_vec [0:(1<<sgns_pkg::ADDR_W)-1];
  bit in_known [0:(1<<sgns_pkg::ADDR_W)-1];
  bit out_known [0:(1<<sgns_pkg::ADDR_W)-1];
  logic signed [31:0] err_acc [0:sgns_pkg::MAX_DIM-1];
  logic [16:0] sig_lut [0:sgns_pkg::TABLE_ENTRIES-1];
  logic [9:0] dim_reg = sgns_pkg::DIM_RESET;

  step_result_t result_q [$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_rx = 1'b0;
  bit pressure_go = 1'b0;
  int mismatches = 0;
  int beats_out = 0;
  int beats_in = 0;
  int trains = 0;
  int cycles = 0;
  logic [9:0] pool_rows [4] = '{10'd0, 10'd1023, 10'd341, 10'd682};

  function automatic logic [16:0] sig_point(int i);
    longint mag2, span;
    longint unsigned one, u, t, e, num, den;
    longint acc;
    mag2 = 2 * longint'(i) - sgns_pkg::TABLE_ENTRIES;
    span = (mag2 < 0) ? -mag2 : mag2;
    one = 64'd1 << 31;
    u = ((64'd6 * span) << 25) / sgns_pkg::TABLE_ENTRIES;
    t = one;
    acc = longint'(one);
    for (int k = 1; k <= 12; k++) begin
      t = ((t * u) >> 31) / k;
      acc = (k & 1) ? acc - longint'(t) : acc + longint'(t);
    end
    e = (acc < 0) ? 0 : acc;
    repeat (6) e = (e * e) >> 31;
    num = (mag2 >= 0) ? one : e;
    den = one + e;
    return 17'(((num << 16) + den / 2) / den);
  endfunction

  function automatic longint round_q12(longint x);
    return (x + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic logic signed [15:0] clip16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sh7fffffff) return 32'sh7fffffff;
    if (x < -64'sh80000000) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic int eff_dim();
    return (dim_reg > sgns_pkg::MAX_DIM) ? sgns_pkg::MAX_DIM : dim_reg;
  endfunction

  task automatic apply_step(input step_item_t it, output step_result_t r);
    int n;
    longint dot, g, idx;
    logic [16:0] p;
    logic [sgns_pkg::ADDR_W-1:0] ia, ta;
    n = eff_dim();
    r = '0;
    ia = {it.irow, it.el};
    ta = {it.trow, it.el};
    case (it.op)
      sgns_pkg::OP_TRAIN: begin
        dot = 0;
        for (int c = 0; c < n; c++)
          dot += longint'(in_vec[{it.irow, 9'(c)}]) * longint'(out_vec[{it.trow, 9'(c)}]);
        if (dot > longint'(sgns_pkg::SIX_Q24)) p = 17'd65536;
        else if (dot < -longint'(sgns_pkg::SIX_Q24)) p = 17'd0;
        else begin
          idx = ((dot + longint'(sgns_pkg::SIX_Q24)) * sgns_pkg::SIG_SCALE) >>> 24;
          if (idx >= sgns_pkg::TABLE_ENTRIES) idx = sgns_pkg::TABLE_ENTRIES - 1;
          p = sig_lut[idx];
        end
        g = (longint'(it.lab) * 65536 - longint'(p)) * longint'(it.rate);
        for (int c = 0; c < n; c++)
          err_acc[c] = clip32(longint'(err_acc[c]) +
                              round_q12(g * longint'(out_vec[{it.trow, 9'(c)}])));
        for (int c = 0; c < n; c++)
          out_vec[{it.trow, 9'(c)}] = clip16(longint'(out_vec[{it.trow, 9'(c)}]) +
                                             round_q12(g * longint'(in_vec[{it.irow, 9'(c)}])));
        r.pred = p;
        trains++;
      end
      OP_SPARE6, OP_SPARE7: ;
      default: begin
        if (it.el >= n) r.st = 1'b1;
        else case (it.op)
          sgns_pkg::OP_WR_IN: begin
            in_vec[ia] = it.wval;
            in_known[ia] = 1'b1;
          end
          sgns_pkg::OP_WR_OUT: begin
            out_vec[ta] = it.wval;
            out_known[ta] = 1'b1;
          end
          sgns_pkg::OP_RD_IN: r.rd = 32'(in_vec[ia]);
          sgns_pkg::OP_RD_OUT: r.rd = 32'(out_vec[ta]);
          default: begin
            r.rd = err_acc[it.el];
            err_acc[it.el] = '0;
          end
        endcase
      end
    endcase
  endtask

  task automatic send_item(input step_item_t it, input bit fixed, input step_result_t typed);
    step_result_t r;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, it.rate, it.lab, it.wval, it.el, it.trow, it.irow};
    s_tuser <= it.op;
    do @(posedge clk); while (!s_tready);
    apply_step(it, r);
    result_q.push_back(fixed ? typed : r);
    beats_in++;
  endtask

  task automatic write_dim(input logic [9:0] v);
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dim_reg = v;
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
  endtask

  task automatic make_item(output step_item_t it);
    int pick, n;
    n = eff_dim();
    it.irow = ($urandom_range(1)) ? pool_rows[$urandom_range(3)] : 10'($urandom);
    it.trow = ($urandom_range(1)) ? pool_rows[$urandom_range(3)] : 10'($urandom);
    it.el = ($urandom_range(9) < 8 && n > 0) ? 9'($urandom_range(n - 1)) : 9'($urandom);
    it.wval = ($urandom_range(9) < 7) ? 16'($signed(12'($urandom))) : 16'($urandom);
    it.lab = 1'($urandom);
    it.rate = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) it.op = sgns_pkg::OP_TRAIN;
    else if (pick < 55) it.op = sgns_pkg::OP_WR_IN;
    else if (pick < 70) it.op = sgns_pkg::OP_WR_OUT;
    else if (pick < 80) it.op = sgns_pkg::OP_RD_IN;
    else if (pick < 90) it.op = sgns_pkg::OP_RD_OUT;
    else if (pick < 97) it.op = sgns_pkg::OP_RD_ERR;
    else it.op = pick[0] ? OP_SPARE6 : OP_SPARE7;
    // pool rows are filled only up to FILL_EL elements
    if (it.op == sgns_pkg::OP_TRAIN && n > FILL_EL)
      it.op = pick[0] ? sgns_pkg::OP_WR_IN : sgns_pkg::OP_WR_OUT;
    if (it.op == sgns_pkg::OP_TRAIN) begin
      it.irow = pool_rows[$urandom_range(3)];
      it.trow = pool_rows[$urandom_range(3)];
    end
    if (it.el < n && it.op == sgns_pkg::OP_RD_IN && !in_known[{it.irow, it.el}]) begin
      it.irow = pool_rows[$urandom_range(3)];
      it.el = {3'b0, it.el[5:0]};
    end
    if (it.el < n && it.op == sgns_pkg::OP_RD_OUT && !out_known[{it.trow, it.el}]) begin
      it.trow = pool_rows[$urandom_range(3)];
      it.el = {3'b0, it.el[5:0]};
    end
  endtask

  // rows 0..6 run at the reset length, the rest after the pool rows are filled
  // rows 12..15 train at length 64, rows 7..11 and 16..22 run at full length
  dir_row_t dir_rows [23] = '{
    '{'{sgns_pkg::OP_RD_ERR, 10'd0, 10'd0, 9'd0, 16'h0, 1'b0, 16'h0}, 1'b1,
      '{32'd0, 17'd0, 1'b0}},
    '{'{sgns_pkg::OP_RD_IN, 10'd5, 10'd0, 9'd300, 16'h0, 1'b0, 16'h0}, 1'b1,
      '{32'd0, 17'd0, 1'b1}},
    '{'{sgns_pkg::OP_WR_IN, 10'd5, 10'd0, 9'd511, 16'h1234, 1'b0, 16'h0}, 1'b1,
      '{32'd0, 17'd0, 1'b1}},
    '{'{OP_SPARE6, 10'd1023, 10'd1023, 9'd511, 16'hffff, 1'b1, 16'hffff}, 1'b1, '0},
    '{'{OP_SPARE7, 10'd0, 10'd0, 9'd0, 16'h0, 1'b0, 16'h0}, 1'b1, '0},
    '{'{sgns_pkg::OP_WR_IN, 10'd5, 10'd0, 9'd299, 16'h8000, 1'b0, 16'h0}, 1'b1, '0},
    '{'{sgns_pkg::OP_RD_IN, 10'd5, 10'd0, 9'd299, 16'h0, 1'b0, 16'h0}, 1'b1,
      '{32'hffff8000, 17'd0, 1'b0}},
    '{'{sgns_pkg::OP_RD_ERR, 10'd0, 10'd0, 9'd511, 16'h0, 1'b0, 16'h0}, 1'b1,
      '{32'd0, 17'd0, 1'b0}},
    '{'{sgns_pkg::OP_WR_IN, 10'd0, 10'd0, 9'd0, 16'h7fff, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_WR_OUT, 10'd0, 10'd1023, 9'd0, 16'h7fff, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_WR_OUT, 10'd0, 10'd1023, 9'd511, 16'h8000, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_WR_IN, 10'd1023, 10'd0, 9'd511, 16'h8000, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_TRAIN, 10'd0, 10'd1023, 9'd0, 16'h0, 1'b1, 16'hffff}, 1'b0, '0},
    '{'{sgns_pkg::OP_TRAIN, 10'd0, 10'd1023, 9'd0, 16'h0, 1'b0, 16'hffff}, 1'b0, '0},
    '{'{sgns_pkg::OP_TRAIN, 10'd1023, 10'd0, 9'd0, 16'h0, 1'b1, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_TRAIN, 10'd341, 10'd682, 9'd0, 16'h0, 1'b1, 16'h8000}, 1'b0, '0},
    '{'{sgns_pkg::OP_RD_OUT, 10'd0, 10'd1023, 9'd0, 16'h0, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_RD_OUT, 10'd0, 10'd1023, 9'd511, 16'h0, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_RD_IN, 10'd1023, 10'd0, 9'd511, 16'h0, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_RD_ERR, 10'd0, 10'd0, 9'd0, 16'h0, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_RD_ERR, 10'd0, 10'd0, 9'd0, 16'h0, 1'b0, 16'h0}, 1'b1,
      '{32'd0, 17'd0, 1'b0}},
    '{'{sgns_pkg::OP_RD_ERR, 10'd0, 10'd0, 9'd511, 16'h0, 1'b0, 16'h0}, 1'b0, '0},
    '{'{sgns_pkg::OP_WR_OUT, 10'd0, 10'd682, 9'd1, 16'h7fff, 1'b0, 16'h0}, 1'b0, '0}
  };

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
      $display("sgns_gradient_step verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    step_result_t want, got;
    if (m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[48:32], m_tdata[49]};
      beats_out++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected rd %h pred %h st %b, got rd %h pred %h st %b",
                     beats_out, want.rd, want.pred, want.st, got.rd, got.pred, got.st);
        end
      end
    end
    m_tready <= !rst && !hold_rx && !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
  end

  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    step_item_t it;
    static int dims [6] = '{1023, 0, 1, 7, 300, 64};
    static int counts [6] = '{40, 40, 80, 100, 60, 130};
    for (int i = 0; i < sgns_pkg::TABLE_ENTRIES; i++) sig_lut[i] = sig_point(i);
    for (int i = 0; i < sgns_pkg::MAX_DIM; i++) err_acc[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 7; i++) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

    // fill the front of the pool rows of both tables with small values
    write_dim(10'd1023);
    set_idling(0, 30);
    for (int r = 0; r < 4; r++)
      for (int e = 0; e < FILL_EL; e++) begin
        it = '{sgns_pkg::OP_WR_IN, pool_rows[r], pool_rows[r], 9'(e),
               16'($signed(11'($urandom))), 1'b0, 16'h0};
        send_item(it, 1'b0, '0);
        it.op = sgns_pkg::OP_WR_OUT;
        it.wval = 16'($signed(11'($urandom)));
        send_item(it, 1'b0, '0);
      end
    set_idling(0, 0);
    for (int i = 7; i < 12; i++) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);
    write_dim(10'(FILL_EL));
    for (int i = 12; i < 16; i++) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);
    write_dim(10'd1023);
    for (int i = 16; i < 23; i++) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      write_dim(10'(dims[ph]));
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(56, 0);
        2: set_idling(0, 56);
        default: set_idling(6, 6);
      endcase
      if (ph == 4) pressure_go = 1'b1;
      for (int k = 0; k < counts[ph]; k++) begin
        make_item(it);
        send_item(it, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items (%0d train steps) over six lengths from 0 to 1023,", beats_in,
             trains);
    $display("with sender gaps, receiver stalls and one long output hold; %0d mismatches",
             mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("sgns_gradient_step verification clean");
    end else begin
      $display("sgns_gradient_step verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sgns_pkg.sv
hw/rtl/sgns_ram.sv
hw/rtl/sgns_gradient_step.sv
tb/sgns_gradient_step_tb.sv
